[rtl/ddms_pkg.sv]
package ddms_pkg;

    // joystick axis and motor value formats
    localparam int AXIS_CENTRE = 2047;
    localparam int PWM_MAX     = 255;
    localparam int AXIS_IN_W   = 12;
    localparam int AXIS_W      = 13;   // centred axis, signed
    localparam int MIX_W       = 14;   // speed +- dir, signed
    localparam int MAG_W       = 11;   // clamped magnitude
    localparam int PWM_W       = 8;
    localparam int TIME_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // register reset values
    localparam logic [MAG_W-1:0]  DEAD_ZONE_RST   = MAG_W'(100);
    localparam logic [PWM_W-1:0]  MIN_PWM_RST     = PWM_W'(0);
    localparam logic [PWM_W-1:0]  SLEW_AMOUNT_RST = PWM_W'(255);
    localparam logic [TIME_W-1:0] SLEW_TIME_RST   = TIME_W'(500);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_ZONE   = 2'd0,
        REG_MIN_PWM     = 2'd1,
        REG_SLEW_AMOUNT = 2'd2,
        REG_SLEW_TIME   = 2'd3
    } cfg_reg_t;

    // centre a raw axis on AXIS_CENTRE, fold the one extra positive code
    function automatic logic signed [AXIS_W-1:0] centre_axis(input logic [AXIS_IN_W-1:0] raw);
        logic signed [AXIS_W-1:0] v;
        v = $signed({1'b0, raw}) - $signed(AXIS_W'(AXIS_CENTRE));
        if (v == $signed(AXIS_W'(AXIS_CENTRE + 1)))
            v = $signed(AXIS_W'(AXIS_CENTRE));
        return v;
    endfunction

    // absolute value clamped to AXIS_CENTRE
    function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [MIX_W-1:0] s);
        logic [MIX_W-1:0] a;
        a = s[MIX_W-1] ? MIX_W'(-s) : MIX_W'(s);
        if (a > MIX_W'(AXIS_CENTRE))
            return MAG_W'(AXIS_CENTRE);
        return a[MAG_W-1:0];
    endfunction

endpackage

[rtl/differential_drive_mixer_slew_top.sv]
// one shared restoring divider runs three divisions of 8+FRAC_BITS one-bit steps per item
//   (slew step, left mapping, right mapping); a new beat is taken only once the previous
//   result has been written to the result register, which waits while the output is held
// reset: rst_n async active low; registers return to their defaults, both motor values to zero,
//   no result is pending and the block is ready at once
module differential_drive_mixer_slew_top
    import ddms_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // command channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [AXIS_IN_W-1:0]  speed_in,
    input  logic [AXIS_IN_W-1:0]  dir_in,
    input  logic [TIME_W-1:0]     elapsed_ms,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PWM_W-1:0]      left_fwd,
    output logic [PWM_W-1:0]      left_bwd,
    output logic [PWM_W-1:0]      right_fwd,
    output logic [PWM_W-1:0]      right_bwd,
    output logic                  left_active,
    output logic                  right_active
);

    // quotient width: slew step is at most slew_amount << FRAC_BITS
    localparam int QW    = PWM_W + FRAC_BITS;
    // dividend: (elapsed * slew_amount) << FRAC_BITS
    localparam int PRODW = TIME_W + PWM_W;
    localparam int NUMW  = PRODW + FRAC_BITS;
    // divisor aligned to the top quotient bit
    localparam int DW    = TIME_W + QW - 1;
    localparam int CW    = $clog2(QW);
    // stored motor value: signed, FRAC_BITS fraction bits, room for last +- step
    localparam int VW    = PWM_W + 2 + FRAC_BITS;
    localparam int MAPW  = MAG_W + PWM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        JOB_STEP,
        JOB_LEFT,
        JOB_RIGHT
    } job_t;

    // control state
    state_t              state_reg, state_next;
    job_t                job_reg, job_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    // configuration
    logic [MAG_W-1:0]    dead_zone_reg, dead_zone_next;
    logic [PWM_W-1:0]    min_pwm_reg, min_pwm_next;
    logic [PWM_W-1:0]    slew_amount_reg, slew_amount_next;
    logic [TIME_W-1:0]   slew_time_reg, slew_time_next;

    // smoothed motor values
    logic signed [VW-1:0] left_value_reg, left_value_next;
    logic signed [VW-1:0] right_value_reg, right_value_next;

    // per-item datapath
    logic [MAG_W-1:0]    mag_l_reg, mag_l_next;
    logic [MAG_W-1:0]    mag_r_reg, mag_r_next;
    logic                neg_l_reg, neg_l_next;
    logic                neg_r_reg, neg_r_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [PRODW-1:0]    prod_reg, prod_next;
    logic [NUMW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]       div_reg, div_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [QW-1:0]       step_reg, step_next;
    logic signed [VW-1:0] tgt_l_reg, tgt_l_next;
    logic signed [VW-1:0] tgt_r_reg, tgt_r_next;

    // result register
    logic [PWM_W-1:0]    left_fwd_reg, left_fwd_next;
    logic [PWM_W-1:0]    left_bwd_reg, left_bwd_next;
    logic [PWM_W-1:0]    right_fwd_reg, right_fwd_next;
    logic [PWM_W-1:0]    right_bwd_reg, right_bwd_next;
    logic                left_active_reg, left_active_next;
    logic                right_active_reg, right_active_next;

    logic                       in_fire;
    logic                       finish_fire;
    logic signed [AXIS_W-1:0]   spd_c;
    logic signed [AXIS_W-1:0]   dir_c;
    logic signed [MIX_W-1:0]    mix_l;
    logic signed [MIX_W-1:0]    mix_r;
    logic [MAG_W-1:0]           sel_mag;
    logic                       sel_neg;
    logic [MAG_W-1:0]           span;
    logic [MAPW-1:0]            map_num;
    logic [NUMW-1:0]            load_num;
    logic [TIME_W-1:0]          load_den;
    logic [NUMW-1:0]            div_ext;
    logic                       div_ge;
    logic [PWM_W:0]             map_sum;
    logic [PWM_W-1:0]           map_pwm;
    logic signed [VW-1:0]       map_tgt;
    logic                       long_gap;
    logic signed [VW-1:0]       new_l;
    logic signed [VW-1:0]       new_r;

    // move last toward tgt by at most step, stopping at the target; jump goes straight to it
    function automatic logic signed [VW-1:0] slew_lane(
        input logic signed [VW-1:0] last,
        input logic signed [VW-1:0] tgt,
        input logic [QW-1:0]        step,
        input logic                 jump
    );
        logic signed [VW-1:0] stp;
        logic signed [VW-1:0] cur;
        stp = $signed(VW'(step));
        if (jump)
            return tgt;
        if (last < tgt)
        begin
            cur = last + stp;
            return (cur > tgt) ? tgt : cur;
        end
        cur = last - stp;
        return (cur < tgt) ? tgt : cur;
    endfunction

    // direction bytes from a smoothed value, whole duty steps truncated toward zero
    function automatic logic [PWM_W-1:0] fwd_byte(input logic signed [VW-1:0] v);
        if (v > $signed(VW'(0)))
            return v[FRAC_BITS +: PWM_W];
        return '0;
    endfunction

    function automatic logic [PWM_W-1:0] bwd_byte(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] n;
        n = -v;
        if (v < $signed(VW'(0)))
            return n[FRAC_BITS +: PWM_W];
        return '0;
    endfunction

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    // the result register is free or drains this cycle
    assign finish_fire = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    // mixing, done as the beat is taken
    assign spd_c = centre_axis(speed_in);
    assign dir_c = centre_axis(dir_in);
    assign mix_l = MIX_W'(spd_c) + MIX_W'(dir_c);
    assign mix_r = MIX_W'(spd_c) - MIX_W'(dir_c);

    // divider operand selection for the current job
    assign sel_mag = (job_reg == JOB_RIGHT) ? mag_r_reg : mag_l_reg;
    assign sel_neg = (job_reg == JOB_RIGHT) ? neg_r_reg : neg_l_reg;
    assign span    = MAG_W'(AXIS_CENTRE) - dead_zone_reg;
    // only meaningful above the dead zone, otherwise the quotient is dropped
    assign map_num = MAPW'(sel_mag - dead_zone_reg) * MAPW'(PWM_W'(PWM_MAX) - min_pwm_reg);

    always_comb
    begin
        case (job_reg)
            JOB_STEP:
            begin
                load_num = {prod_reg, {FRAC_BITS{1'b0}}};
                load_den = slew_time_reg;
            end
            JOB_LEFT, JOB_RIGHT:
            begin
                load_num = NUMW'(map_num);
                load_den = TIME_W'(span);
            end
            default:
            begin
                load_num = '0;
                load_den = '0;
            end
        endcase
    end

    // restoring divider step
    assign div_ext = NUMW'(div_reg);
    assign div_ge  = (rem_reg >= div_ext);

    // target from the finished mapping quotient
    assign map_sum = {1'b0, quo_reg[PWM_W-1:0]} + {1'b0, min_pwm_reg};
    assign map_pwm = map_sum[PWM_W] ? PWM_W'(PWM_MAX) : map_sum[PWM_W-1:0];

    always_comb
    begin
        if ((sel_mag == '0) || (sel_mag <= dead_zone_reg))
            map_tgt = '0;
        else if (sel_neg)
            map_tgt = -$signed(VW'({map_pwm, {FRAC_BITS{1'b0}}}));
        else
            map_tgt = $signed(VW'({map_pwm, {FRAC_BITS{1'b0}}}));
    end

    // long gaps and a zero interval jump straight to the target
    assign long_gap = (slew_time_reg == '0) || (elapsed_reg > slew_time_reg);
    assign new_l    = slew_lane(left_value_reg, tgt_l_reg, step_reg, long_gap);
    assign new_r    = slew_lane(right_value_reg, tgt_r_reg, step_reg, long_gap);

    always_comb
    begin
        state_next        = state_reg;
        job_next          = job_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg;
        dead_zone_next    = dead_zone_reg;
        min_pwm_next      = min_pwm_reg;
        slew_amount_next  = slew_amount_reg;
        slew_time_next    = slew_time_reg;
        left_value_next   = left_value_reg;
        right_value_next  = right_value_reg;
        mag_l_next        = mag_l_reg;
        mag_r_next        = mag_r_reg;
        neg_l_next        = neg_l_reg;
        neg_r_next        = neg_r_reg;
        elapsed_next      = elapsed_reg;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        div_next          = div_reg;
        quo_next          = quo_reg;
        step_next         = step_reg;
        tgt_l_next        = tgt_l_reg;
        tgt_r_next        = tgt_r_reg;
        left_fwd_next     = left_fwd_reg;
        left_bwd_next     = left_bwd_reg;
        right_fwd_next    = right_fwd_reg;
        right_bwd_next    = right_bwd_reg;
        left_active_next  = left_active_reg;
        right_active_next = right_active_reg;

        // register writes
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEAD_ZONE:   dead_zone_next   = cfg_data[MAG_W-1:0];
                REG_MIN_PWM:     min_pwm_next     = cfg_data[PWM_W-1:0];
                REG_SLEW_AMOUNT: slew_amount_next = cfg_data[PWM_W-1:0];
                REG_SLEW_TIME:   slew_time_next   = cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end

        // result beat leaves
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mag_l_next   = clamp_mag(mix_l);
                    mag_r_next   = clamp_mag(mix_r);
                    neg_l_next   = mix_l[MIX_W-1];
                    neg_r_next   = mix_r[MIX_W-1];
                    elapsed_next = elapsed_ms;
                    prod_next    = PRODW'(elapsed_ms) * PRODW'(slew_amount_reg);
                    job_next     = JOB_STEP;
                    state_next   = S_LOAD;
                end
            end
            S_LOAD:
            begin
                rem_next   = load_num;
                div_next   = {load_den, {(QW-1){1'b0}}};
                quo_next   = '0;
                cnt_next   = CW'(QW - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_ge)
                    rem_next = rem_reg - div_ext;
                quo_next = {quo_reg[QW-2:0], div_ge};
                div_next = div_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                case (job_reg)
                    JOB_STEP:
                    begin
                        step_next  = quo_reg;
                        job_next   = JOB_LEFT;
                        state_next = S_LOAD;
                    end
                    JOB_LEFT:
                    begin
                        tgt_l_next = map_tgt;
                        job_next   = JOB_RIGHT;
                        state_next = S_LOAD;
                    end
                    default:
                    begin
                        tgt_r_next = map_tgt;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_FINISH:
            begin
                if (finish_fire)
                begin
                    left_value_next   = new_l;
                    right_value_next  = new_r;
                    left_fwd_next     = fwd_byte(new_l);
                    left_bwd_next     = bwd_byte(new_l);
                    right_fwd_next    = fwd_byte(new_r);
                    right_bwd_next    = bwd_byte(new_r);
                    left_active_next  = (new_l != '0);
                    right_active_next = (new_r != '0);
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, configuration and the smoothed values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            job_reg         <= JOB_STEP;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            dead_zone_reg   <= DEAD_ZONE_RST;
            min_pwm_reg     <= MIN_PWM_RST;
            slew_amount_reg <= SLEW_AMOUNT_RST;
            slew_time_reg   <= SLEW_TIME_RST;
            left_value_reg  <= '0;
            right_value_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            job_reg         <= job_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            dead_zone_reg   <= dead_zone_next;
            min_pwm_reg     <= min_pwm_next;
            slew_amount_reg <= slew_amount_next;
            slew_time_reg   <= slew_time_next;
            left_value_reg  <= left_value_next;
            right_value_reg <= right_value_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        mag_l_reg        <= mag_l_next;
        mag_r_reg        <= mag_r_next;
        neg_l_reg        <= neg_l_next;
        neg_r_reg        <= neg_r_next;
        elapsed_reg      <= elapsed_next;
        prod_reg         <= prod_next;
        rem_reg          <= rem_next;
        div_reg          <= div_next;
        quo_reg          <= quo_next;
        step_reg         <= step_next;
        tgt_l_reg        <= tgt_l_next;
        tgt_r_reg        <= tgt_r_next;
        left_fwd_reg     <= left_fwd_next;
        left_bwd_reg     <= left_bwd_next;
        right_fwd_reg    <= right_fwd_next;
        right_bwd_reg    <= right_bwd_next;
        left_active_reg  <= left_active_next;
        right_active_reg <= right_active_next;
    end

    assign out_valid    = out_valid_reg;
    assign left_fwd     = left_fwd_reg;
    assign left_bwd     = left_bwd_reg;
    assign right_fwd    = right_fwd_reg;
    assign right_bwd    = right_bwd_reg;
    assign left_active  = left_active_reg;
    assign right_active = right_active_reg;

`ifndef SYNTHESIS
    // a new result only comes out of the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish step");

    // smoothed values stay within full duty
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_value_reg <= $signed(VW'(PWM_MAX << FRAC_BITS))) &&
        (left_value_reg >= -$signed(VW'(PWM_MAX << FRAC_BITS))) &&
        (right_value_reg <= $signed(VW'(PWM_MAX << FRAC_BITS))) &&
        (right_value_reg >= -$signed(VW'(PWM_MAX << FRAC_BITS))))
        else $error("motor value out of range");

    // a motor never drives both directions
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !((left_fwd_reg != '0) && (left_bwd_reg != '0)) &&
                          !((right_fwd_reg != '0) && (right_bwd_reg != '0)))
        else $error("both directions driven");

    // divider runs exactly its step count before storing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |-> $past(state_reg == S_DIV) && $past(cnt_reg == '0))
        else $error("divider stored early");
`endif

endmodule
